>>> rtl/core/msl_pkg.sv
// Shared types, constants and register codes for the multi-stack LIFO unit.
package msl_pkg;

   localparam int NUM_STACKS_DEF  = 8;
   localparam int STACK_DEPTH_DEF = 32;

   localparam int SEL_W      = 3;
   localparam int VALUE_W    = 32;
   localparam int LEVEL_W    = 32;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POP_PROTECT  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_PUSH_PROTECT = CSR_INDEX_W'(1);

   // one stack word: flag bit above the 32-bit value
   typedef struct packed {
      logic               flag;
      logic [VALUE_W-1:0] value;
   } word_type;

   // per-request outcome of the level update
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               pop_fault;
      logic               push_fault;
      logic               pop_sticky;
      logic               push_sticky;
      logic               push_done;
   } step_type;

endpackage

>>> rtl/core/msl_word_mem.sv
// Stack word memory with registered read port and clearing pass after reset.
module msl_word_mem #(
   parameter int NUM_STACKS  = msl_pkg::NUM_STACKS_DEF,
   parameter int STACK_DEPTH = msl_pkg::STACK_DEPTH_DEF,
   localparam int IDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1,
   localparam int ADDR_W = $clog2(STACK_DEPTH),
   localparam int MEM_AW = IDX_W + ADDR_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [MEM_AW-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [MEM_AW-1:0] wr_addr,
   input  msl_pkg::word_type wr_data,
   output msl_pkg::word_type rd_data,
   output logic              busy
);
   import msl_pkg::*;

   localparam int MEM_DEPTH = NUM_STACKS << ADDR_W;
   localparam logic [MEM_AW-1:0] LAST_ADDR = MEM_AW'(MEM_DEPTH - 1);

   word_type          mem [0:MEM_DEPTH-1];
   word_type          rd_data_ff;
   logic              busy_ff, busy_in;
   logic [MEM_AW-1:0] clr_cnt_ff, clr_cnt_in;

   // sweep every entry to zero once after reset
   always_comb begin
      busy_in    = busy_ff;
      clr_cnt_in = clr_cnt_ff;
      if (busy_ff) begin
         if (clr_cnt_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + MEM_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

>>> rtl/core/msl_level_ctrl.sv
// Level and sticky-fault state: applies clear, pop and push of each request.
module msl_level_ctrl #(
   parameter int NUM_STACKS  = msl_pkg::NUM_STACKS_DEF,
   parameter int STACK_DEPTH = msl_pkg::STACK_DEPTH_DEF,
   localparam int IDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1,
   localparam int ADDR_W = $clog2(STACK_DEPTH),
   localparam int MEM_AW = IDX_W + ADDR_W
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       accept,
   input  logic [msl_pkg::SEL_W-1:0]                  stack_select,
   input  logic                                       clear_req,
   input  logic                                       pop_req,
   input  logic                                       push_req,
   input  logic                                       pop_protect,
   input  logic                                       push_protect,
   output logic                                       sel_ok,
   output logic [IDX_W-1:0]                           idx,
   output msl_pkg::step_type                          step,
   output logic [MEM_AW-1:0]                          rd_addr,
   output logic                                       wr_en,
   output logic [MEM_AW-1:0]                          wr_addr,
   output logic [NUM_STACKS-1:0][msl_pkg::LEVEL_W-1:0] levels
);
   import msl_pkg::*;

   localparam logic [ADDR_W-1:0]  ADDR_MASK = ADDR_W'(STACK_DEPTH - 1);
   localparam logic [LEVEL_W-1:0] FULL_LVL  = LEVEL_W'(STACK_DEPTH);

   logic [NUM_STACKS-1:0][LEVEL_W-1:0] level_ff;
   logic [NUM_STACKS-1:0]              under_ff, over_ff;
   logic [LEVEL_W-1:0]                 lvl_pre, lvl_pop, lvl_new;
   logic                               pop_err, push_err, push_do, pop_move;
   logic                               under_new, over_new;

   assign sel_ok = (32'(stack_select) < NUM_STACKS);
   assign idx    = IDX_W'(stack_select);

   always_comb begin
      lvl_pre   = clear_req ? '0 : level_ff[idx];
      pop_err   = pop_req && (lvl_pre == '0);
      pop_move  = pop_req && (!pop_err || !pop_protect);
      lvl_pop   = pop_move ? (lvl_pre - LEVEL_W'(1)) : lvl_pre;
      push_err  = push_req && (lvl_pop == FULL_LVL);
      push_do   = push_req && (!push_err || !push_protect);
      lvl_new   = push_do ? (lvl_pop + LEVEL_W'(1)) : lvl_pop;
      under_new = (!clear_req && under_ff[idx]) || pop_err;
      over_new  = (!clear_req && over_ff[idx]) || push_err;
   end

   always_comb begin
      step.level       = lvl_new;
      step.pop_fault   = pop_err;
      step.push_fault  = push_err;
      step.pop_sticky  = under_new;
      step.push_sticky = over_new;
      step.push_done   = push_do;
   end

   // read the word that becomes the top after any pop, write the pushed word
   assign rd_addr = {idx, lvl_pop[ADDR_W-1:0] & ADDR_MASK};
   assign wr_addr = {idx, lvl_new[ADDR_W-1:0] & ADDR_MASK};
   assign wr_en   = accept && sel_ok && push_do;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         under_ff <= '0;
         over_ff  <= '0;
      end else if (accept && sel_ok) begin
         level_ff[idx] <= lvl_new;
         under_ff[idx] <= under_new;
         over_ff[idx]  <= over_new;
      end
   end

   assign levels = level_ff;

endmodule

>>> rtl/core/msl_history.sv
// Cached top words of all stacks and the snapshot history registers.
module msl_history #(
   parameter int NUM_STACKS = msl_pkg::NUM_STACKS_DEF,
   localparam int IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       advance,
   input  logic                                       sel_ok,
   input  logic [IDX_W-1:0]                           idx,
   input  logic                                       clear_req,
   input  logic                                       snapshot_req,
   input  logic                                       push_done,
   input  msl_pkg::word_type                          push_word,
   input  msl_pkg::word_type                          rd_word,
   input  logic [NUM_STACKS-1:0][msl_pkg::LEVEL_W-1:0] levels,
   output msl_pkg::word_type                          top_word,
   output msl_pkg::word_type                          hist_word,
   output logic [msl_pkg::LEVEL_W-1:0]                hist_level
);
   import msl_pkg::*;

   word_type [NUM_STACKS-1:0]              top_ff, top_in;
   word_type [NUM_STACKS-1:0]              saved_top_ff, saved_top_in;
   logic     [NUM_STACKS-1:0][LEVEL_W-1:0] saved_lvl_ff, saved_lvl_in;

   always_comb begin
      for (int k = 0; k < NUM_STACKS; k++) begin
         top_in[k]       = top_ff[k];
         saved_top_in[k] = saved_top_ff[k];
         saved_lvl_in[k] = saved_lvl_ff[k];
         if (sel_ok && (IDX_W'(k) == idx)) begin
            top_in[k] = push_done ? push_word : rd_word;
            if (clear_req) begin
               saved_top_in[k] = '0;
               saved_lvl_in[k] = '0;
            end
         end
         if (snapshot_req) begin
            saved_top_in[k] = top_in[k];
            saved_lvl_in[k] = levels[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         saved_top_ff <= '0;
         saved_lvl_ff <= '0;
      end else if (advance) begin
         top_ff       <= top_in;
         saved_top_ff <= saved_top_in;
         saved_lvl_ff <= saved_lvl_in;
      end
   end

   assign top_word   = top_in[idx];
   assign hist_word  = saved_top_in[idx];
   assign hist_level = saved_lvl_in[idx];

endmodule

>>> rtl/core/multi_stack_lifo_unit.sv
// Stage 1 feeds the output register; one request per cycle while req_stall is low.
// Stage 1 updates levels and faults and reads the stack memory; stage 2 updates tops/history.
// A stalled result holds in the output register while the next request is still taken.
// Reset (synchronous): levels, faults, tops and history clear; protect bits set to 1.
// After reset the NUM_STACKS * 2**clog2(STACK_DEPTH) memory words (256 at defaults) are
// swept to zero with req_stall high; csr writes are taken throughout.
module multi_stack_lifo_unit #(
   parameter int NUM_STACKS  = msl_pkg::NUM_STACKS_DEF,
   parameter int STACK_DEPTH = msl_pkg::STACK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [msl_pkg::SEL_W-1:0]         req_stack_select,
   input  logic                              req_clear_req,
   input  logic                              req_pop_req,
   input  logic                              req_push_req,
   input  logic [msl_pkg::VALUE_W-1:0]       req_push_value,
   input  logic                              req_push_flag,
   input  logic                              req_snapshot_req,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [msl_pkg::VALUE_W-1:0]       rsp_top_value,
   output logic                              rsp_top_flag,
   output logic [msl_pkg::LEVEL_W-1:0]       rsp_fill_level,
   output logic                              rsp_pop_fault,
   output logic                              rsp_push_fault,
   output logic                              rsp_pop_fault_sticky,
   output logic                              rsp_push_fault_sticky,
   output logic [msl_pkg::VALUE_W-1:0]       rsp_history_value,
   output logic                              rsp_history_flag,
   output logic [msl_pkg::LEVEL_W-1:0]       rsp_history_level,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [msl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic                              csr_data
);
   import msl_pkg::*;

   localparam int IDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int MEM_AW = IDX_W + ADDR_W;

   // ------------------------------------------------------------------
   // Configuration registers; writes must only be issued while idle, which
   // the block does not enforce; the port is always ready.
   // ------------------------------------------------------------------
   logic pop_protect_ff, push_protect_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_protect_ff  <= 1'b1;
         push_protect_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POP_PROTECT:  pop_protect_ff  <= csr_data;
            CSR_PUSH_PROTECT: push_protect_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake. Stage 1 holds one request; it moves into the output
   // register when that register is empty or being drained.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_advance, accept, mem_busy;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = mem_busy || (s1_valid_ff && !s1_advance);
   assign accept     = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------------------------
   // Accept stage: level/fault update and memory access.
   // ------------------------------------------------------------------
   logic                              sel_ok;
   logic [IDX_W-1:0]                  idx;
   step_type                          step;
   logic [MEM_AW-1:0]                 rd_addr, wr_addr;
   logic                              wr_en;
   logic [NUM_STACKS-1:0][LEVEL_W-1:0] levels;
   word_type                          push_word, rd_word;

   assign push_word.flag  = req_push_flag;
   assign push_word.value = req_push_value;

   msl_level_ctrl #(
      .NUM_STACKS  (NUM_STACKS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_level (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .stack_select (req_stack_select),
      .clear_req    (req_clear_req),
      .pop_req      (req_pop_req),
      .push_req     (req_push_req),
      .pop_protect  (pop_protect_ff),
      .push_protect (push_protect_ff),
      .sel_ok       (sel_ok),
      .idx          (idx),
      .step         (step),
      .rd_addr      (rd_addr),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .levels       (levels)
   );

   // read data lands with the request in stage 1
   msl_word_mem #(
      .NUM_STACKS  (NUM_STACKS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_word),
      .rd_data (rd_word),
      .busy    (mem_busy)
   );

   // ------------------------------------------------------------------
   // Stage 1 payload: hold while stalled.
   // ------------------------------------------------------------------
   logic             s1_sel_ok_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic             s1_clear_ff, s1_snap_ff;
   step_type         s1_step_ff;
   word_type         s1_word_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sel_ok_ff <= sel_ok;
         s1_idx_ff    <= idx;
         s1_clear_ff  <= req_clear_req;
         s1_snap_ff   <= req_snapshot_req;
         s1_step_ff   <= step;
         s1_word_ff   <= push_word;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: top cache and history, committed when stage 1 advances.
   // Levels seen here already include this request and nothing later.
   // ------------------------------------------------------------------
   word_type           top_word, hist_word;
   logic [LEVEL_W-1:0] hist_level;

   msl_history #(
      .NUM_STACKS (NUM_STACKS)
   ) u_hist (
      .clock        (clock),
      .reset        (reset),
      .advance      (s1_advance),
      .sel_ok       (s1_sel_ok_ff),
      .idx          (s1_idx_ff),
      .clear_req    (s1_clear_ff),
      .snapshot_req (s1_snap_ff),
      .push_done    (s1_step_ff.push_done),
      .push_word    (s1_word_ff),
      .rd_word      (rd_word),
      .levels       (levels),
      .top_word     (top_word),
      .hist_word    (hist_word),
      .hist_level   (hist_level)
   );

   // ------------------------------------------------------------------
   // Output register; a request naming a missing stack reports all zero.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         if (s1_sel_ok_ff) begin
            rsp_top_value         <= top_word.value;
            rsp_top_flag          <= top_word.flag;
            rsp_fill_level        <= s1_step_ff.level;
            rsp_pop_fault         <= s1_step_ff.pop_fault;
            rsp_push_fault        <= s1_step_ff.push_fault;
            rsp_pop_fault_sticky  <= s1_step_ff.pop_sticky;
            rsp_push_fault_sticky <= s1_step_ff.push_sticky;
            rsp_history_value     <= hist_word.value;
            rsp_history_flag      <= hist_word.flag;
            rsp_history_level     <= hist_level;
         end else begin
            rsp_top_value         <= '0;
            rsp_top_flag          <= 1'b0;
            rsp_fill_level        <= '0;
            rsp_pop_fault         <= 1'b0;
            rsp_push_fault        <= 1'b0;
            rsp_pop_fault_sticky  <= 1'b0;
            rsp_push_fault_sticky <= 1'b0;
            rsp_history_value     <= '0;
            rsp_history_flag      <= 1'b0;
            rsp_history_level     <= '0;
         end
      end
   end

endmodule
